// ----- hw/rtl/spfp_pkg.sv -----
// ----------------------------------------------------------------------------
// spfp_pkg
// Shared widths, register codes and the pipeline work record of the screened
// pair force kernel.
// ----------------------------------------------------------------------------
`default_nettype none

package spfp_pkg;

	// Field widths fixed by the data formats
	localparam int POS_W  = 24;  // Q8.16 position
	localparam int DX_W   = 26;  // folded separation, signed
	localparam int D2_W   = 50;  // squared distance, Q16.32
	localparam int IRS_W  = 48;  // radius squared register
	localparam int R_W    = 25;  // distance, Q8.16
	localparam int ACC_W  = 51;  // shared remainder of root and divider
	localparam int Q1_W   = 49;  // quotient bits of e*2^18 / d2
	localparam int E_W    = 31;  // Q2.30 exp values
	localparam int PROD_W = 62;
	localparam int MAG_W  = 40;  // force magnitude, Q16.16
	localparam int HALF_W = 20;  // magnitude split for the projection products
	localparam int PP_W   = 45;  // 20 x 25 partial product
	localparam int NUM_W  = 65;  // magnitude times separation
	localparam int Q2_W   = 40;  // projected force quotient
	localparam int OUT_W  = 40;
	localparam int TCF_W  = 32;
	localparam int CFG_W  = 48;
	localparam int POW_N  = 32;  // entries of the integer power table

	// Configuration register codes
	typedef enum logic [2:0] {
		CFG_BOX_SIZE  = 3'd0,
		CFG_INV_LEN   = 3'd1,
		CFG_RADIUS_SQ = 3'd2,
		CFG_MIN_DIST  = 3'd3,
		CFG_CLOSE_F   = 3'd4
	} cfg_reg_t;

	// Reset values of the configuration registers
	localparam logic [POS_W-1:0] BOX_RST   = 24'd1048576;
	localparam logic [POS_W-1:0] INV_RST   = 24'd262144;
	localparam logic [IRS_W-1:0] RSQ_RST   = 48'd154618822656;
	localparam logic [POS_W-1:0] MIND_RST  = 24'd13107;
	localparam logic [TCF_W-1:0] CLOSE_RST = 32'd6553600;

	// Everything one pair carries down the pipeline
	typedef struct packed {
		logic                    last;
		logic signed [DX_W-1:0]  dx;
		logic signed [DX_W-1:0]  dy;
		logic                    hit;
		logic                    close;
		logic                    big;
		logic [4:0]              n;
		logic [15:0]             w;
		logic [D2_W-1:0]         d2;
		logic [R_W-1:0]          r;
		logic [ACC_W-1:0]        acc;
		logic [Q1_W-1:0]         quo;
		logic [E_W-1:0]          hi;
		logic [E_W-1:0]          lo;
		logic [E_W-1:0]          pw;
		logic [PROD_W-1:0]       prod;
		logic [MAG_W-1:0]        mag;
		logic [PP_W-1:0]         xl;
		logic [PP_W-1:0]         xh;
		logic [PP_W-1:0]         yl;
		logic [PP_W-1:0]         yh;
		logic [NUM_W-1:0]        px;
		logic [NUM_W-1:0]        py;
		logic [R_W-1:0]          rx;
		logic [R_W-1:0]          ry;
		logic [Q2_W-1:0]         qx;
		logic [Q2_W-1:0]         qy;
	} work_t;

endpackage

`default_nettype wire

// ----- hw/rtl/screened_pair_force_periodic.sv -----
// ----------------------------------------------------------------------------
// screened_pair_force_periodic
// Screened Coulomb pair force with minimum-image fold, fully pipelined.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) takes one neighbor pair per transfer:
//   two indices, two Q8.16 positions and the end-of-list mark.
//   Output channel (out_valid / out_stall) returns one result per pair, in
//   order: indices, Q16.16 force on the second particle, flags, list mark.
//   Config channel (cfg_valid / cfg_ready / cfg_index / cfg_data) writes the
//   five registers; always ready; write only while the pipeline is empty.
// Throughput: one pair per clock unless out_stall holds the pipeline. Most of
//   its stages come from the bit-per-stage square root (25 stages), the
//   force divider (49 stages) and the projection dividers (40 stages).
// Reset: arst_n clears all valid bits and loads the register defaults.
// Stall: when a result waits under out_stall the whole pipeline holds and
//   in_stall rises in the same cycle; nothing is lost or repeated.
// ----------------------------------------------------------------------------
`default_nettype none

module screened_pair_force_periodic
	import spfp_pkg::*;
#(
	parameter int MAX_PARTICLES   = 1024,
	parameter int EXP_TABLE_DEPTH = 256
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	// configuration
	input  wire logic                             cfg_valid,
	output logic                                  cfg_ready,
	input  wire logic [2:0]                       cfg_index,
	input  wire logic [CFG_W-1:0]                 cfg_data,
	// pair input
	input  wire logic                             in_valid,
	output logic                                  in_stall,
	input  wire logic [$clog2(MAX_PARTICLES)-1:0] pair_first,
	input  wire logic [$clog2(MAX_PARTICLES)-1:0] pair_second,
	input  wire logic [POS_W-1:0]                 first_x,
	input  wire logic [POS_W-1:0]                 first_y,
	input  wire logic [POS_W-1:0]                 second_x,
	input  wire logic [POS_W-1:0]                 second_y,
	input  wire logic                             last_pair,
	// force output
	output logic                                  out_valid,
	input  wire logic                             out_stall,
	output logic [$clog2(MAX_PARTICLES)-1:0]      out_first,
	output logic [$clog2(MAX_PARTICLES)-1:0]      out_second,
	output logic signed [OUT_W-1:0]               force_x,
	output logic signed [OUT_W-1:0]               force_y,
	output logic                                  interacts,
	output logic                                  too_close,
	output logic                                  out_last
);

	localparam int IDX_W = $clog2(MAX_PARTICLES);
	localparam int IW    = $clog2(EXP_TABLE_DEPTH + 1);
	localparam int PW    = 16 + IW;

	// Stage positions
	localparam int ST_FOLD = 0;
	localparam int ST_SQ   = 1;
	localparam int ST_SUM  = 2;
	localparam int ST_RT0  = 3;
	localparam int ST_MUL  = ST_RT0 + R_W;
	localparam int ST_AI   = ST_MUL + 1;
	localparam int ST_TAB  = ST_AI + 1;
	localparam int ST_DIF  = ST_TAB + 1;
	localparam int ST_INT  = ST_DIF + 1;
	localparam int ST_POW  = ST_INT + 1;
	localparam int ST_EXP  = ST_POW + 1;
	localparam int ST_DV0  = ST_EXP + 1;
	localparam int ST_MAG  = ST_DV0 + Q1_W;
	localparam int ST_PP   = ST_MAG + 1;
	localparam int ST_NUM  = ST_PP + 1;
	localparam int ST_PQ0  = ST_NUM + 1;
	localparam int NST     = ST_PQ0 + Q2_W;

	localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
	localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};
	localparam logic [Q2_W-1:0]         NEG_LIM = {1'b1, {(Q2_W-1){1'b0}}};

	// ---------------------------------------------------------------- tables
	typedef logic [E_W-1:0] frac_tab_t [EXP_TABLE_DEPTH+1];
	typedef logic [E_W-1:0] pow_tab_t  [POW_N];

	// Restoring unsigned divide, used only while building the tables
	function automatic longint unsigned div_u64(
		input longint unsigned num,
		input longint unsigned den
	);
		longint unsigned q;
		longint unsigned rem;
		q   = '0;
		rem = '0;
		for (int b = 63; b >= 0; b--) begin
			rem = {rem[62:0], num[b]};
			if (rem >= den) begin
				rem  = rem - den;
				q[b] = 1'b1;
			end
		end
		return q;
	endfunction

	// exp(-i/depth) in Q2.30 from a 21-term series
	function automatic frac_tab_t build_frac();
		frac_tab_t         t;
		longint unsigned   x;
		longint unsigned   term;
		longint            sum;
		for (int i = 0; i <= EXP_TABLE_DEPTH; i++) begin
			x    = div_u64(64'(i) << 30, 64'(EXP_TABLE_DEPTH));
			term = 64'd1 << 30;
			sum  = longint'(64'd1 << 30);
			for (int k = 1; k <= 20; k++) begin
				term = div_u64((term * x) >> 30, 64'(k));
				if ((k & 1) == 1) begin
					sum = sum - longint'(term);
				end else begin
					sum = sum + longint'(term);
				end
			end
			if (sum < 0) sum = 0;
			if (sum > longint'(64'd1 << 30)) sum = longint'(64'd1 << 30);
			t[i] = sum[E_W-1:0];
		end
		return t;
	endfunction

	localparam frac_tab_t EXP_FRAC = build_frac();

	// exp(-n) in Q2.30 by repeated rounding product
	function automatic pow_tab_t build_pow();
		pow_tab_t        t;
		longint unsigned p;
		p    = 64'd1 << 30;
		t[0] = p[E_W-1:0];
		for (int n = 1; n < POW_N; n++) begin
			p    = (p * longint'(EXP_FRAC[EXP_TABLE_DEPTH]) + (64'd1 << 29)) >> 30;
			t[n] = p[E_W-1:0];
		end
		return t;
	endfunction

	localparam pow_tab_t EXP_POW = build_pow();

	// Single minimum-image fold of one separation
	function automatic logic signed [DX_W-1:0] fold_d(
		input logic signed [27:0] d,
		input logic signed [27:0] len
	);
		logic signed [27:0] v;
		v = d;
		if ((v <<< 1) > len) v = v - len;
		if ((v <<< 1) <= -len) v = v + len;
		return v[DX_W-1:0];
	endfunction

	// -------------------------------------------------------- configuration
	logic [POS_W-1:0] box_q;
	logic [POS_W-1:0] inv_len_q;
	logic [IRS_W-1:0] radius_sq_q;
	logic [POS_W-1:0] min_dist_q;
	logic [TCF_W-1:0] close_f_q;

	assign cfg_ready = 1'b1;

	// Load registers on a config transfer, drop unknown indexes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			box_q       <= BOX_RST;
			inv_len_q   <= INV_RST;
			radius_sq_q <= RSQ_RST;
			min_dist_q  <= MIND_RST;
			close_f_q   <= CLOSE_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_BOX_SIZE:  box_q       <= cfg_data[POS_W-1:0];
				CFG_INV_LEN:   inv_len_q   <= cfg_data[POS_W-1:0];
				CFG_RADIUS_SQ: radius_sq_q <= cfg_data[IRS_W-1:0];
				CFG_MIN_DIST:  min_dist_q  <= cfg_data[POS_W-1:0];
				CFG_CLOSE_F:   close_f_q   <= cfg_data[TCF_W-1:0];
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------- pipeline
	work_t            work_s   [NST];
	work_t            nxt      [NST];
	logic [NST-1:0]   vld_s;
	logic [IDX_W-1:0] first_s  [NST];
	logic [IDX_W-1:0] second_s [NST];
	logic [IW-1:0]    tab_idx_s;
	logic [IW-1:0]    tab_idx_d;
	logic             adv;

	// Advance everything unless a result waits under stall
	assign adv      = !out_valid || !out_stall;
	assign in_stall = !adv;

	// Fold both separations to the nearest image
	always_comb begin
		nxt[ST_FOLD]      = '0;
		nxt[ST_FOLD].last = last_pair;
		nxt[ST_FOLD].dx   = fold_d($signed({4'b0, second_x}) - $signed({4'b0, first_x}),
			$signed({4'b0, box_q}));
		nxt[ST_FOLD].dy   = fold_d($signed({4'b0, second_y}) - $signed({4'b0, first_y}),
			$signed({4'b0, box_q}));
	end

	// Square the separations
	always_comb begin
		logic signed [2*DX_W-1:0] sx;
		logic signed [2*DX_W-1:0] sy;
		sx = work_s[ST_SQ-1].dx * work_s[ST_SQ-1].dx;
		sy = work_s[ST_SQ-1].dy * work_s[ST_SQ-1].dy;
		nxt[ST_SQ]    = work_s[ST_SQ-1];
		nxt[ST_SQ].px = NUM_W'($unsigned(sx));
		nxt[ST_SQ].py = NUM_W'($unsigned(sy));
	end

	// Sum to d2, test the radius, seed the root
	always_comb begin
		logic [D2_W-1:0] d2;
		d2 = work_s[ST_SUM-1].px[D2_W-1:0] + work_s[ST_SUM-1].py[D2_W-1:0];
		nxt[ST_SUM]     = work_s[ST_SUM-1];
		nxt[ST_SUM].d2  = d2;
		nxt[ST_SUM].hit = d2 < {{(D2_W-IRS_W){1'b0}}, radius_sq_q};
		nxt[ST_SUM].acc = {1'b0, d2};
		nxt[ST_SUM].quo = '0;
	end

	// Integer square root, one result bit per stage
	for (genvar j = 0; j < R_W; j++) begin : g_root
		localparam int B = R_W - 1 - j;
		always_comb begin
			logic [ACC_W-1:0] c;
			c = ({{(ACC_W-R_W){1'b0}}, work_s[ST_RT0+j-1].quo[R_W-1:0]} << (B + 1))
				+ (ACC_W'(1) << (2 * B));
			nxt[ST_RT0+j] = work_s[ST_RT0+j-1];
			if (work_s[ST_RT0+j-1].acc >= c) begin
				nxt[ST_RT0+j].acc    = work_s[ST_RT0+j-1].acc - c;
				nxt[ST_RT0+j].quo[B] = 1'b1;
			end
		end
	end

	// Take r, flag too-close pairs, scale by the inverse length
	always_comb begin
		logic [R_W-1:0] r;
		r = work_s[ST_MUL-1].quo[R_W-1:0];
		nxt[ST_MUL]       = work_s[ST_MUL-1];
		nxt[ST_MUL].r     = r;
		nxt[ST_MUL].close = work_s[ST_MUL-1].hit && (r < {1'b0, min_dist_q});
		nxt[ST_MUL].prod  = PROD_W'(r) * PROD_W'(inv_len_q);
	end

	// Round the exponent, split integer part and table position
	always_comb begin
		logic [D2_W-1:0] a_full;
		logic [PW-1:0]   p;
		a_full = work_s[ST_AI-1].prod[D2_W-1:0] + D2_W'(32'h8000);
		p      = PW'(a_full[31:16]) * PW'(EXP_TABLE_DEPTH);
		nxt[ST_AI]     = work_s[ST_AI-1];
		nxt[ST_AI].n   = a_full[36:32];
		nxt[ST_AI].big = |a_full[D2_W-1:37];
		nxt[ST_AI].w   = p[15:0];
		tab_idx_d      = p[PW-1:16];
	end

	// Read the fraction and power tables
	always_comb begin
		nxt[ST_TAB]    = work_s[ST_TAB-1];
		nxt[ST_TAB].hi = EXP_FRAC[tab_idx_s];
		nxt[ST_TAB].lo = EXP_FRAC[tab_idx_s + IW'(1)];
		nxt[ST_TAB].pw = EXP_POW[work_s[ST_TAB-1].n];
	end

	// Interpolation step times weight
	always_comb begin
		nxt[ST_DIF]      = work_s[ST_DIF-1];
		nxt[ST_DIF].prod = PROD_W'(work_s[ST_DIF-1].hi - work_s[ST_DIF-1].lo)
			* PROD_W'(work_s[ST_DIF-1].w);
	end

	// Interpolated fraction, kept in hi
	always_comb begin
		logic [PROD_W-1:0] t;
		t = work_s[ST_INT-1].prod + PROD_W'(32'h8000);
		nxt[ST_INT]    = work_s[ST_INT-1];
		nxt[ST_INT].hi = work_s[ST_INT-1].hi - t[E_W+15:16];
	end

	// Integer power times fraction
	always_comb begin
		nxt[ST_POW]      = work_s[ST_POW-1];
		nxt[ST_POW].prod = PROD_W'(work_s[ST_POW-1].pw) * PROD_W'(work_s[ST_POW-1].hi);
	end

	// Round to Q2.30, zero past the table, seed the force divider
	always_comb begin
		logic [PROD_W:0] t;
		logic [E_W-1:0]  e;
		t = {1'b0, work_s[ST_EXP-1].prod} + (PROD_W+1)'(32'h2000_0000);
		e = work_s[ST_EXP-1].big ? '0 : t[E_W+29:30];
		nxt[ST_EXP]     = work_s[ST_EXP-1];
		nxt[ST_EXP].quo = {e, 18'b0};
		nxt[ST_EXP].acc = '0;
	end

	// e*2^18 / d2, one quotient bit per stage
	for (genvar j = 0; j < Q1_W; j++) begin : g_fdiv
		always_comb begin
			logic [ACC_W-1:0] t;
			logic             ge;
			t  = {work_s[ST_DV0+j-1].acc[ACC_W-2:0], work_s[ST_DV0+j-1].quo[Q1_W-1]};
			ge = t >= {1'b0, work_s[ST_DV0+j-1].d2};
			nxt[ST_DV0+j]     = work_s[ST_DV0+j-1];
			nxt[ST_DV0+j].quo = {work_s[ST_DV0+j-1].quo[Q1_W-2:0], ge};
			nxt[ST_DV0+j].acc = ge ? t - {1'b0, work_s[ST_DV0+j-1].d2} : t;
		end
	end

	// Select the magnitude: fixed, saturated formula or none
	always_comb begin
		work_t pv;
		pv = work_s[ST_MAG-1];
		nxt[ST_MAG] = pv;
		if (!pv.hit) begin
			nxt[ST_MAG].mag = '0;
		end else if (pv.close) begin
			nxt[ST_MAG].mag = MAG_W'(close_f_q);
		end else if (pv.d2 != '0) begin
			nxt[ST_MAG].mag = (|pv.quo[Q1_W-1:MAG_W]) ? '1 : pv.quo[MAG_W-1:0];
		end else begin
			nxt[ST_MAG].mag = '0;
		end
	end

	// Partial products of magnitude and separation
	always_comb begin
		logic [R_W-1:0] ax;
		logic [R_W-1:0] ay;
		work_t          pv;
		pv = work_s[ST_PP-1];
		ax = pv.dx[DX_W-1] ? R_W'(-pv.dx) : R_W'(pv.dx);
		ay = pv.dy[DX_W-1] ? R_W'(-pv.dy) : R_W'(pv.dy);
		nxt[ST_PP]    = pv;
		nxt[ST_PP].xl = PP_W'(pv.mag[HALF_W-1:0]) * PP_W'(ax);
		nxt[ST_PP].xh = PP_W'(pv.mag[MAG_W-1:HALF_W]) * PP_W'(ax);
		nxt[ST_PP].yl = PP_W'(pv.mag[HALF_W-1:0]) * PP_W'(ay);
		nxt[ST_PP].yh = PP_W'(pv.mag[MAG_W-1:HALF_W]) * PP_W'(ay);
	end

	// Combine the partial products
	always_comb begin
		nxt[ST_NUM]    = work_s[ST_NUM-1];
		nxt[ST_NUM].px = (NUM_W'(work_s[ST_NUM-1].xh) << HALF_W) + NUM_W'(work_s[ST_NUM-1].xl);
		nxt[ST_NUM].py = (NUM_W'(work_s[ST_NUM-1].yh) << HALF_W) + NUM_W'(work_s[ST_NUM-1].yl);
	end

	// Divide both projections by r; the quotient never exceeds the magnitude
	for (genvar j = 0; j < Q2_W; j++) begin : g_pdiv
		always_comb begin
			logic [R_W:0]   tx;
			logic [R_W:0]   ty;
			logic           gx;
			logic           gy;
			work_t          pv;
			pv = work_s[ST_PQ0+j-1];
			if (j == 0) begin
				tx = {pv.px[NUM_W-1:Q2_W], pv.px[Q2_W-1-j]};
				ty = {pv.py[NUM_W-1:Q2_W], pv.py[Q2_W-1-j]};
			end else begin
				tx = {pv.rx, pv.px[Q2_W-1-j]};
				ty = {pv.ry, pv.py[Q2_W-1-j]};
			end
			gx = tx >= {1'b0, pv.r};
			gy = ty >= {1'b0, pv.r};
			nxt[ST_PQ0+j]    = pv;
			nxt[ST_PQ0+j].rx = gx ? R_W'(tx - {1'b0, pv.r}) : R_W'(tx);
			nxt[ST_PQ0+j].ry = gy ? R_W'(ty - {1'b0, pv.r}) : R_W'(ty);
			nxt[ST_PQ0+j].qx = {pv.qx[Q2_W-2:0], gx};
			nxt[ST_PQ0+j].qy = {pv.qy[Q2_W-2:0], gy};
		end
	end

	// Pipeline valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (adv) begin
			vld_s <= {vld_s[NST-2:0], in_valid};
		end
	end

	// Pipeline payload
	always_ff @(posedge clk) begin
		if (adv) begin
			first_s[0]  <= pair_first;
			second_s[0] <= pair_second;
			for (int k = 0; k < NST; k++) begin
				work_s[k] <= nxt[k];
			end
			for (int k = 1; k < NST; k++) begin
				first_s[k]  <= first_s[k-1];
				second_s[k] <= second_s[k-1];
			end
			tab_idx_s <= tab_idx_d;
		end
	end

	// ------------------------------------------------------------- output
	logic signed [OUT_W-1:0] fx_d;
	logic signed [OUT_W-1:0] fy_d;

	// Apply sign and saturate
	always_comb begin
		work_t pv;
		pv = work_s[NST-1];
		if (pv.r == '0) begin
			fx_d = '0;
		end else if (pv.dx[DX_W-1]) begin
			fx_d = (pv.qx > NEG_LIM) ? OUT_MIN : -$signed(pv.qx);
		end else begin
			fx_d = (pv.qx > Q2_W'(OUT_MAX)) ? OUT_MAX : $signed(pv.qx);
		end
		if (pv.r == '0) begin
			fy_d = '0;
		end else if (pv.dy[DX_W-1]) begin
			fy_d = (pv.qy > NEG_LIM) ? OUT_MIN : -$signed(pv.qy);
		end else begin
			fy_d = (pv.qy > Q2_W'(OUT_MAX)) ? OUT_MAX : $signed(pv.qy);
		end
	end

	// Output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= vld_s[NST-1];
		end
	end

	// Output payload, held while stalled
	always_ff @(posedge clk) begin
		if (adv) begin
			out_first  <= first_s[NST-1];
			out_second <= second_s[NST-1];
			force_x    <= fx_d;
			force_y    <= fy_d;
			interacts  <= work_s[NST-1].hit;
			too_close  <= work_s[NST-1].close;
			out_last   <= work_s[NST-1].last;
		end
	end

	// ---------------------------------------------------------- assertions
	a_close_in_radius: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && too_close |-> interacts)
		else $error("too-close result outside the radius");

	a_zero_outside: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !interacts |-> force_x == '0 && force_y == '0)
		else $error("nonzero force for a pair outside the radius");

	a_tail_reaches_out: assert property (@(posedge clk) disable iff (!arst_n)
		adv && vld_s[NST-1] |=> out_valid)
		else $error("pipeline tail lost on the way to the output");

	a_hold_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(vld_s))
		else $error("pipeline moved while held");

endmodule

`default_nettype wire

// ----- test/pair_force_checker.sv -----
// ----------------------------------------------------------------------------
// pair_force_checker
// Watches the configuration, pair and force channels of the screened pair
// force kernel. It keeps its own copy of the registers, works out the force of
// every accepted pair and compares each returned result field by field.
// ----------------------------------------------------------------------------
module pair_force_checker
	import spfp_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	input  logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [CFG_W-1:0]   cfg_data,
	input  logic               in_valid,
	input  logic               in_stall,
	input  logic [9:0]         pair_first,
	input  logic [9:0]         pair_second,
	input  logic [POS_W-1:0]   first_x,
	input  logic [POS_W-1:0]   first_y,
	input  logic [POS_W-1:0]   second_x,
	input  logic [POS_W-1:0]   second_y,
	input  logic               last_pair,
	input  logic               out_valid,
	input  logic               out_stall,
	input  logic [9:0]         out_first,
	input  logic [9:0]         out_second,
	input  logic [OUT_W-1:0]   force_x,
	input  logic [OUT_W-1:0]   force_y,
	input  logic               interacts,
	input  logic               too_close,
	input  logic               out_last,
	output int                 fails,
	output int                 pending
);

	localparam int FRAC_STEPS = 256;

	typedef struct packed {
		logic [9:0]       first;
		logic [9:0]       second;
		logic [OUT_W-1:0] fx;
		logic [OUT_W-1:0] fy;
		logic             hit;
		logic             close;
		logic             last;
	} pair_force_t;

	pair_force_t expected_forces[$];

	// register copy
	logic [POS_W-1:0] box_len;
	logic [POS_W-1:0] inv_screen;
	logic [IRS_W-1:0] radius_sq;
	logic [POS_W-1:0] near_dist;
	logic [TCF_W-1:0] near_force;

	// exp(-i/256) and exp(-n), Q2.30
	longint unsigned frac_exp[0:FRAC_STEPS];
	longint unsigned int_exp[0:31];

	initial begin
		longint unsigned x, term;
		longint sum;
		for (int i = 0; i <= FRAC_STEPS; i++) begin
			x = (longint'(i) << 30) / FRAC_STEPS;
			term = 64'd1 << 30;
			sum = longint'(64'd1 << 30);
			for (int k = 1; k <= 20; k++) begin
				term = ((term * x) >> 30) / k;
				if (k % 2 == 1) sum -= longint'(term);
				else sum += longint'(term);
			end
			if (sum < 0) sum = 0;
			if (sum > longint'(64'd1 << 30)) sum = longint'(64'd1 << 30);
			frac_exp[i] = longint'(sum);
		end
		int_exp[0] = 64'd1 << 30;
		for (int n = 1; n < 32; n++)
			int_exp[n] = (int_exp[n-1] * frac_exp[FRAC_STEPS] + (64'd1 << 29)) >> 30;
	end

	function automatic longint unsigned sqrt_floor(longint unsigned v);
		longint unsigned res, probe;
		res = 0;
		probe = 64'd1 << 62;
		while (probe > v) probe >>= 2;
		while (probe != 0) begin
			if (v >= res + probe) begin
				v -= res + probe;
				res = (res >> 1) + probe;
			end else begin
				res >>= 1;
			end
			probe >>= 2;
		end
		return res;
	endfunction

	// nearest image, one fold each way
	function automatic longint min_image(longint d);
		longint len;
		len = longint'(box_len);
		if (2 * d > len) d -= len;
		if (2 * d <= -len) d += len;
		return d;
	endfunction

	function automatic longint unsigned exp_neg_q30(longint unsigned a);
		longint unsigned n, p, i, w, hi, lo, m;
		n = a >> 16;
		if (n >= 32) return 0;
		p = (a & 64'hFFFF) * FRAC_STEPS;
		i = p >> 16;
		w = p & 64'hFFFF;
		hi = frac_exp[i];
		lo = frac_exp[i+1];
		m = hi - (((hi - lo) * w + 64'h8000) >> 16);
		return (int_exp[n] * m + (64'd1 << 29)) >> 30;
	endfunction

	// project the magnitude on one axis, saturate to 40 bits signed
	function automatic logic [OUT_W-1:0] axis_force(longint unsigned mag, longint d,
			longint unsigned r);
		logic [127:0] q;
		longint unsigned ad;
		ad = (d < 0) ? longint'(-d) : longint'(d);
		if (r == 0 || ad == 0) return '0;
		q = (128'(mag) * 128'(ad)) / 128'(r);
		if (d < 0) begin
			if (q > (128'd1 << 39)) return {1'b1, 39'd0};
			return OUT_W'(-q);
		end
		if (q > (128'd1 << 39) - 1) return {1'b0, {39{1'b1}}};
		return OUT_W'(q);
	endfunction

	function automatic pair_force_t pair_force();
		pair_force_t res;
		longint dx, dy;
		longint unsigned d2, r, mag, a;
		res = '0;
		dx = min_image(longint'(second_x) - longint'(first_x));
		dy = min_image(longint'(second_y) - longint'(first_y));
		d2 = longint'(dx * dx) + longint'(dy * dy);
		mag = 0;
		if (d2 < radius_sq) begin
			res.hit = 1'b1;
			r = sqrt_floor(d2);
			if (r < near_dist) begin
				res.close = 1'b1;
				mag = near_force;
			end else if (d2 != 0) begin
				a = (r * inv_screen + 64'h8000) >> 16;
				mag = (exp_neg_q30(a) << 18) / d2;
				if (mag > (64'd1 << 40) - 1) mag = (64'd1 << 40) - 1;
			end
			res.fx = axis_force(mag, dx, r);
			res.fy = axis_force(mag, dy, r);
		end
		res.first = pair_first;
		res.second = pair_second;
		res.last = last_pair;
		return res;
	endfunction

	// track registers, predict on pair transfers, compare on result transfers
	always @(posedge clk or negedge arst_n) begin
		pair_force_t want;
		if (!arst_n) begin
			box_len <= BOX_RST;
			inv_screen <= INV_RST;
			radius_sq <= RSQ_RST;
			near_dist <= MIND_RST;
			near_force <= CLOSE_RST;
			expected_forces.delete();
			fails = 0;
			pending = 0;
		end else begin
			if (in_valid && !in_stall)
				expected_forces.push_back(pair_force());
			if (out_valid && !out_stall) begin
				if (expected_forces.size() == 0) begin
					$error("force result with no pair outstanding");
					fails++;
				end else begin
					want = expected_forces.pop_front();
					if (out_first !== want.first) begin
						$error("out_first: expected %0d, got %0d", want.first, out_first);
						fails++;
					end
					if (out_second !== want.second) begin
						$error("out_second: expected %0d, got %0d", want.second, out_second);
						fails++;
					end
					if (force_x !== want.fx) begin
						$error("force_x: expected %0d, got %0d",
							$signed(want.fx), $signed(force_x));
						fails++;
					end
					if (force_y !== want.fy) begin
						$error("force_y: expected %0d, got %0d",
							$signed(want.fy), $signed(force_y));
						fails++;
					end
					if (interacts !== want.hit) begin
						$error("interacts: expected %0d, got %0d", want.hit, interacts);
						fails++;
					end
					if (too_close !== want.close) begin
						$error("too_close: expected %0d, got %0d", want.close, too_close);
						fails++;
					end
					if (out_last !== want.last) begin
						$error("out_last: expected %0d, got %0d", want.last, out_last);
						fails++;
					end
				end
			end
			pending = expected_forces.size();
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_BOX_SIZE: box_len <= cfg_data[POS_W-1:0];
					CFG_INV_LEN: inv_screen <= cfg_data[POS_W-1:0];
					CFG_RADIUS_SQ: radius_sq <= cfg_data[IRS_W-1:0];
					CFG_MIN_DIST: near_dist <= cfg_data[POS_W-1:0];
					CFG_CLOSE_F: near_force <= cfg_data[TCF_W-1:0];
					default: ;
				endcase
			end
		end
	end

endmodule

// ----- test/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the screened pair force kernel: a directed set of pairs around
// the fold, radius and too-close boundaries, then random pairs under several
// register settings with random gaps and output stalls. The checker module
// predicts and compares; this module drives and gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;
	import spfp_pkg::*;

	localparam int IDLE_LIMIT = 3000;
	localparam int DRAIN_WAIT = 150;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [2:0] cfg_index = '0;
	logic [CFG_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [9:0] pair_first = '0;
	logic [9:0] pair_second = '0;
	logic [POS_W-1:0] first_x = '0;
	logic [POS_W-1:0] first_y = '0;
	logic [POS_W-1:0] second_x = '0;
	logic [POS_W-1:0] second_y = '0;
	logic last_pair = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [9:0] out_first;
	logic [9:0] out_second;
	logic signed [OUT_W-1:0] force_x;
	logic signed [OUT_W-1:0] force_y;
	logic interacts;
	logic too_close;
	logic out_last;

	int fails;
	int pending;
	int idle_cycles = 0;
	logic calm = 1'b0;
	logic result_taken = 1'b0;
	int stall_left = 0;

	always #1 clk = ~clk;

	screened_pair_force_periodic dut (.*);

	pair_force_checker checker_i (.*);

	// hold the output stall for a random count after each result transfer
	always @(negedge clk) begin
		if (result_taken) stall_left = calm ? 0 : $urandom_range(0, 15);
		out_stall <= (stall_left > 0);
		if (stall_left > 0) stall_left--;
	end

	always @(posedge clk) result_taken <= out_valid && !out_stall;

	// end the run when nothing moves for too long
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	task automatic send_pair(input logic [9:0] f, input logic [9:0] s,
			input logic [POS_W-1:0] fx, input logic [POS_W-1:0] fy,
			input logic [POS_W-1:0] sx, input logic [POS_W-1:0] sy, input logic lst);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 15);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		pair_first <= f;
		pair_second <= s;
		first_x <= fx;
		first_y <= fy;
		second_x <= sx;
		second_y <= sy;
		last_pair <= lst;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
	endtask

	// drop valid and let the pipeline empty
	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (DRAIN_WAIT) @(posedge clk);
		@(negedge clk);
	endtask

	// present one write; the caller drops cfg_valid after the last one
	task automatic write_reg(input logic [2:0] idx, input logic [CFG_W-1:0] val);
		cfg_index <= idx;
		cfg_data <= val;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
	endtask

	task automatic load_setting(input logic [47:0] box, input logic [47:0] kinv,
			input logic [47:0] rsq, input logic [47:0] mind, input logic [47:0] tcf);
		drain();
		write_reg(CFG_BOX_SIZE, box);
		write_reg(CFG_INV_LEN, kinv);
		write_reg(CFG_RADIUS_SQ, rsq);
		write_reg(CFG_MIN_DIST, mind);
		write_reg(CFG_CLOSE_F, tcf);
		cfg_valid <= 1'b0;
	endtask

	// mostly close pairs with random content, some coincident, some anywhere
	task automatic random_pairs(input int count);
		logic [POS_W-1:0] fx, fy, sx, sy;
		int mode, span;
		for (int i = 0; i < count; i++) begin
			fx = POS_W'($urandom());
			fy = POS_W'($urandom());
			mode = $urandom_range(0, 9);
			span = 4 * $urandom_range(1, 6);
			if (mode < 7) begin
				sx = POS_W'(fx + ($urandom() & ((1 << span) - 1)) - (1 << (span - 1)));
				sy = POS_W'(fy + ($urandom() & ((1 << span) - 1)) - (1 << (span - 1)));
			end else if (mode == 7) begin
				sx = fx;
				sy = fy;
			end else begin
				sx = POS_W'($urandom());
				sy = POS_W'($urandom());
			end
			send_pair(10'($urandom_range(0, 1023)), 10'($urandom_range(0, 1023)),
				fx, fy, sx, sy, $urandom_range(0, 7) == 0);
		end
	endtask

	initial begin
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed pairs under the reset setting (box 16.0, radius 6.0)
		calm <= 1'b1;
		send_pair(10'd0, 10'd1023, 24'd0, 24'd0, 24'd0, 24'd0, 1'b0);
		send_pair(10'd1023, 10'd0, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 1'b1);
		send_pair(10'd1, 10'd2, 24'd0, 24'd0, 24'd524288, 24'd0, 1'b0);
		send_pair(10'd3, 10'd4, 24'd0, 24'd0, 24'd524289, 24'd0, 1'b0);
		send_pair(10'd5, 10'd6, 24'd524288, 24'd0, 24'd0, 24'd0, 1'b0);
		send_pair(10'd7, 10'd8, 24'd524289, 24'd0, 24'd0, 24'd0, 1'b0);
		send_pair(10'd9, 10'd10, 24'd100, 24'd100, 24'd1100, 24'd600, 1'b0);
		send_pair(10'd11, 10'd12, 24'd0, 24'd0, 24'd65536, 24'd0, 1'b0);
		send_pair(10'd13, 10'd14, 24'd0, 24'd0, 24'd0, 24'd65536, 1'b0);
		send_pair(10'd15, 10'd16, 24'd0, 24'd0, 24'd393216, 24'd0, 1'b0);
		send_pair(10'd17, 10'd18, 24'd0, 24'd0, 24'd393215, 24'd0, 1'b0);
		send_pair(10'd19, 10'd20, 24'd200000, 24'd200000, 24'd100000, 24'd50000, 1'b0);
		send_pair(10'd21, 10'd22, 24'd0, 24'd0, 24'd13107, 24'd0, 1'b0);
		send_pair(10'd23, 10'd24, 24'd0, 24'd0, 24'd13106, 24'd0, 1'b0);
		send_pair(10'd25, 10'd26, 24'hF00000, 24'h100, 24'hF00000, 24'hFFFFFF, 1'b0);
		send_pair(10'd27, 10'd28, 24'd1048575, 24'd0, 24'd0, 24'd1048575, 1'b1);

		// the sender waits here until every result is back
		drain();
		calm <= 1'b0;
		random_pairs(100);

		// unknown index must not touch any register
		drain();
		write_reg(3'd5, '1);
		write_reg(3'd7, '1);
		cfg_valid <= 1'b0;
		random_pairs(60);

		// upper extremes, data with bits above each register's width
		load_setting('1, '1, '1, '1, '1);
		random_pairs(100);

		// lower extremes, box of zero leaves the separation unfolded
		calm <= 1'b1;
		load_setting(48'd0, 48'd1, 48'd0, 48'd0, 48'd0);
		random_pairs(40);
		load_setting(48'd1, 48'd1, 48'd1 << 40, 48'd0, 48'd0);
		random_pairs(80);

		// no too-close floor so small separations saturate
		calm <= 1'b0;
		load_setting(48'd4194304, 48'd65536, 48'd1 << 46, 48'd0, 48'd6553600);
		random_pairs(120);

		load_setting(48'd196608, 48'd1048576, 48'd1 << 44, 48'd6553, 48'hFFFFFFFF);
		random_pairs(100);

		load_setting(48'hFFFFFF, 48'd300, '1, 48'd500, 48'd100000);
		random_pairs(100);

		load_setting({24'd0, BOX_RST}, {24'd0, INV_RST}, RSQ_RST, {24'd0, MIND_RST},
			{16'd0, CLOSE_RST});
		random_pairs(100);

		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (fails == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

// ----- sim.f -----
hw/rtl/spfp_pkg.sv
hw/rtl/screened_pair_force_periodic.sv
test/pair_force_checker.sv
test/tb_top.sv
